// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fhtf_pkg.sv =====
// ------------------------------------------------------------------------
// fhtf_pkg
// Types, character codes and helpers shared by the hex float formatter.
// ------------------------------------------------------------------------
package fhtf_pkg;

   typedef logic [6:0] ascii_type;
   typedef logic [3:0] chr_sel_type;

   // Character source selected by the controller for the current cycle.
   localparam chr_sel_type SEL_MINUS = 4'd0;
   localparam chr_sel_type SEL_ZERO  = 4'd1;
   localparam chr_sel_type SEL_X     = 4'd2;
   localparam chr_sel_type SEL_LEAD  = 4'd3;
   localparam chr_sel_type SEL_DOT   = 4'd4;
   localparam chr_sel_type SEL_NIB   = 4'd5;
   localparam chr_sel_type SEL_P     = 4'd6;
   localparam chr_sel_type SEL_ESIGN = 4'd7;
   localparam chr_sel_type SEL_DIG   = 4'd8;
   localparam chr_sel_type SEL_I     = 4'd9;
   localparam chr_sel_type SEL_N     = 4'd10;
   localparam chr_sel_type SEL_F     = 4'd11;

   localparam ascii_type CH_MINUS = 7'h2D;
   localparam ascii_type CH_PLUS  = 7'h2B;
   localparam ascii_type CH_ZERO  = 7'h30;
   localparam ascii_type CH_ONE   = 7'h31;
   localparam ascii_type CH_X     = 7'h78;
   localparam ascii_type CH_DOT   = 7'h2E;
   localparam ascii_type CH_P     = 7'h70;
   localparam ascii_type CH_I     = 7'h69;
   localparam ascii_type CH_N     = 7'h6E;
   localparam ascii_type CH_F     = 7'h66;
   localparam ascii_type CH_A     = 7'h61;

   localparam int FRAC_NIBBLES = 13;

   // Controller -> datapath commands.
   typedef struct packed {
      logic        load;
      chr_sel_type sel;
      logic [3:0]  nib_idx;
      logic [1:0]  dig_idx;
   } cmd_type;

   // Datapath -> controller status, valid once the decode registers hold the value.
   typedef struct packed {
      logic       is_nan;
      logic       is_inf;
      logic       neg;
      logic       frac_nz;
      logic [3:0] last_nib;
      logic [1:0] dig_last;
   } status_type;

   function automatic ascii_type hex_char(input logic [3:0] nib);
      ascii_type ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {3'd0, nib};
      end else begin
         ch = CH_A + {3'd0, nib - 4'd10};
      end
      return ch;
   endfunction

endpackage

// ===== rtl/fhtf_ctrl.sv =====
// ------------------------------------------------------------------------
// fhtf_ctrl
// Sequencer: waits out the decode cycles, then steps through the text
// one character per cycle.
// ------------------------------------------------------------------------
module fhtf_ctrl
   import fhtf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd,
   output logic       rsp_strobe,
   output logic       rsp_last_char
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DEC0  = 4'd1;
   localparam logic [3:0] ST_DEC1  = 4'd2;
   localparam logic [3:0] ST_DEC2  = 4'd3;
   localparam logic [3:0] ST_DEC3  = 4'd4;
   localparam logic [3:0] ST_SIGN  = 4'd5;
   localparam logic [3:0] ST_ZERO  = 4'd6;
   localparam logic [3:0] ST_X     = 4'd7;
   localparam logic [3:0] ST_LEAD  = 4'd8;
   localparam logic [3:0] ST_DOT   = 4'd9;
   localparam logic [3:0] ST_NIB   = 4'd10;
   localparam logic [3:0] ST_P     = 4'd11;
   localparam logic [3:0] ST_ESIGN = 4'd12;
   localparam logic [3:0] ST_DIG   = 4'd13;
   localparam logic [3:0] ST_I     = 4'd14;
   localparam logic [3:0] ST_NF    = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [3:0] nib_ff, nib_in;
   logic [1:0] dig_ff, dig_in;
   logic       f_phase_ff, f_phase_in;   // second half of "nf"

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         nib_ff     <= '0;
         dig_ff     <= '0;
         f_phase_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         nib_ff     <= nib_in;
         dig_ff     <= dig_in;
         f_phase_ff <= f_phase_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      nib_in        = nib_ff;
      dig_in        = dig_ff;
      f_phase_in    = f_phase_ff;
      rsp_strobe    = 1'b0;
      rsp_last_char = 1'b0;
      cmd.load      = 1'b0;
      cmd.sel       = SEL_MINUS;
      cmd.nib_idx   = nib_ff;
      cmd.dig_idx   = dig_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DEC0;
            end
         end
         ST_DEC0: state_in = ST_DEC1;
         ST_DEC1: state_in = ST_DEC2;
         ST_DEC2: state_in = ST_DEC3;
         ST_DEC3: begin
            if (status.is_nan) begin
               state_in = ST_IDLE;
            end else if (status.neg) begin
               state_in = ST_SIGN;
            end else if (status.is_inf) begin
               state_in = ST_I;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_SIGN: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_MINUS;
            state_in   = status.is_inf ? ST_I : ST_ZERO;
         end
         ST_ZERO: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_ZERO;
            state_in   = ST_X;
         end
         ST_X: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_X;
            state_in   = ST_LEAD;
         end
         ST_LEAD: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_LEAD;
            state_in   = status.frac_nz ? ST_DOT : ST_P;
         end
         ST_DOT: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_DOT;
            nib_in     = '0;
            state_in   = ST_NIB;
         end
         ST_NIB: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_NIB;
            if (nib_ff == status.last_nib) begin
               state_in = ST_P;
            end else begin
               nib_in = nib_ff + 4'd1;
            end
         end
         ST_P: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_P;
            state_in   = ST_ESIGN;
         end
         ST_ESIGN: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_ESIGN;
            dig_in     = '0;
            state_in   = ST_DIG;
         end
         ST_DIG: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_DIG;
            if (dig_ff == status.dig_last) begin
               rsp_last_char = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               dig_in = dig_ff + 2'd1;
            end
         end
         ST_I: begin
            rsp_strobe = 1'b1;
            cmd.sel    = SEL_I;
            f_phase_in = 1'b0;
            state_in   = ST_NF;
         end
         ST_NF: begin
            rsp_strobe = 1'b1;
            if (f_phase_ff) begin
               cmd.sel       = SEL_F;
               rsp_last_char = 1'b1;
               f_phase_in    = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               cmd.sel    = SEL_N;
               f_phase_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/fhtf_datapath.sv =====
// ------------------------------------------------------------------------
// fhtf_datapath
// Holds the value and mode, decodes fields, converts the exponent to
// decimal digits and selects the character for the current cycle.
// ------------------------------------------------------------------------
module fhtf_datapath
   import fhtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_double_precision,
   input  logic [63:0] req_value_bits,
   input  cmd_type     cmd,
   output status_type  status,
   output ascii_type   rsp_character
);

   // Mode register and captured value.
   logic        dbl_ff;
   logic        mode_ff;
   logic [63:0] bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbl_ff <= 1'b1;
      end else if (csr_write) begin
         dbl_ff <= csr_double_precision;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bits_ff <= req_value_bits;
         mode_ff <= dbl_ff;
      end
   end

   // Decode stage: sign, class, fraction left aligned, exponent magnitude.
   logic        neg_in, nan_in, inf_in, nz_in, eneg_in;
   logic [10:0] bexp;
   logic [51:0] frac_in;
   logic [3:0]  last_in;
   logic [11:0] e_s;
   logic [9:0]  mag_in;
   logic        exp_ones;

   always_comb begin
      if (mode_ff) begin
         neg_in   = bits_ff[63];
         bexp     = bits_ff[62:52];
         frac_in  = bits_ff[51:0];
         exp_ones = &bits_ff[62:52];
      end else begin
         neg_in   = bits_ff[31];
         bexp     = {3'd0, bits_ff[30:23]};
         frac_in  = {bits_ff[22:0], 29'd0};
         exp_ones = &bits_ff[30:23];
      end
      nz_in  = |frac_in;
      nan_in = exp_ones && nz_in;
      inf_in = exp_ones && !nz_in;

      last_in = '0;
      for (int i = 0; i < FRAC_NIBBLES; i++) begin
         if (frac_in[51 - 4*i -: 4] != 4'd0) begin
            last_in = 4'(i);
         end
      end

      if (bexp == 11'd0) begin
         e_s = nz_in ? (mode_ff ? -12'sd1022 : -12'sd126) : 12'd0;
      end else begin
         e_s = {1'b0, bexp} - (mode_ff ? 12'd1023 : 12'd127);
      end
      eneg_in = e_s[11];
      mag_in  = eneg_in ? 10'(-e_s) : e_s[9:0];
   end

   logic        neg_ff, nan_ff, inf_ff, nz_ff, eneg_ff;
   logic [51:0] frac_ff;
   logic [3:0]  last_ff;
   logic [9:0]  mag_ff;

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      nan_ff  <= nan_in;
      inf_ff  <= inf_in;
      nz_ff   <= nz_in;
      eneg_ff <= eneg_in;
      frac_ff <= frac_in;
      last_ff <= last_in;
      mag_ff  <= mag_in;
   end

   // Decimal conversion: thousands by compare, hundreds and tens by
   // reciprocal multiply (exact for the ranges that reach them).
   logic       d3_in;
   logic [9:0] r1_in;
   logic [15:0] h_prod;
   logic       d3_ff;
   logic [9:0] r1_ff;
   logic [3:0] h_ff;
   logic [1:0] dlast_ff, dlast_in;

   always_comb begin
      d3_in  = (mag_ff >= 10'd1000);
      r1_in  = d3_in ? mag_ff - 10'd1000 : mag_ff;
      h_prod = 16'(r1_in * 6'd41);
      if (mag_ff >= 10'd1000) begin
         dlast_in = 2'd3;
      end else if (mag_ff >= 10'd100) begin
         dlast_in = 2'd2;
      end else if (mag_ff >= 10'd10) begin
         dlast_in = 2'd1;
      end else begin
         dlast_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      d3_ff    <= d3_in;
      r1_ff    <= r1_in;
      h_ff     <= h_prod[15:12];
      dlast_ff <= dlast_in;
   end

   logic [6:0] r2_ff;
   logic [9:0] r2_full;
   always_comb begin
      r2_full = r1_ff - 10'(h_ff * 7'd100);
   end

   always_ff @(posedge clock) begin
      r2_ff <= r2_full[6:0];
   end

   logic [13:0] t_prod;
   logic [3:0]  t_ff;
   assign t_prod = 14'(r2_ff * 7'd103);

   always_ff @(posedge clock) begin
      t_ff <= t_prod[13:10];
   end

   logic [6:0] ones_full;
   logic [3:0] ones;
   assign ones_full = r2_ff - 7'(t_ff * 4'd10);
   assign ones      = ones_full[3:0];

   // Leading digit: zero for subnormals and zero.
   logic bexp_zero_ff;
   always_ff @(posedge clock) begin
      bexp_zero_ff <= (bexp == 11'd0);
   end

   // Character select.
   logic [1:0] dig_pos;
   logic [3:0] dig_val;
   logic [3:0] nib_val;

   always_comb begin
      dig_pos = cmd.dig_idx + (2'd3 - dlast_ff);
      case (dig_pos)
         2'd0:    dig_val = {3'd0, d3_ff};
         2'd1:    dig_val = h_ff;
         2'd2:    dig_val = t_ff;
         default: dig_val = ones;
      endcase
      nib_val = frac_ff[51 - 4*cmd.nib_idx -: 4];

      unique case (cmd.sel)
         SEL_MINUS: rsp_character = CH_MINUS;
         SEL_ZERO:  rsp_character = CH_ZERO;
         SEL_X:     rsp_character = CH_X;
         SEL_LEAD:  rsp_character = (bexp_zero_ff) ? CH_ZERO : CH_ONE;
         SEL_DOT:   rsp_character = CH_DOT;
         SEL_NIB:   rsp_character = hex_char(nib_val);
         SEL_P:     rsp_character = CH_P;
         SEL_ESIGN: rsp_character = eneg_ff ? CH_MINUS : CH_PLUS;
         SEL_DIG:   rsp_character = CH_ZERO + {3'd0, dig_val};
         SEL_I:     rsp_character = CH_I;
         SEL_N:     rsp_character = CH_N;
         SEL_F:     rsp_character = CH_F;
         default:   rsp_character = CH_ZERO;
      endcase
   end

   assign status.is_nan   = nan_ff;
   assign status.is_inf   = inf_ff;
   assign status.neg      = neg_ff;
   assign status.frac_nz  = nz_ff;
   assign status.last_nib = last_ff;
   assign status.dig_last = dlast_ff;

endmodule

// ===== rtl/float_hex_text_formatter.sv =====
// ------------------------------------------------------------------------
// float_hex_text_formatter
// Formats one IEEE-754 bit pattern as hexadecimal float text, one ASCII
// character per cycle.
// ------------------------------------------------------------------------
// Usage:
//   Raise start with req_value_bits while busy is low; that edge accepts
//   the transaction. csr_double_precision (csr_valid/csr_ready) picks double
//   (1, reset value) or single taken from bits 31..0; write it while idle.
// Timing:
//   Decode steps follow the accept (fields, thousands/hundreds digit,
//   tens remainder, tens digit), then one character per cycle on
//   rsp_character, marked by rsp_strobe, the final one with rsp_last_char.
//   Busy stays high through the last character, so a new transaction
//   can start only once the current one is done. A NaN emits nothing
//   and frees the block after the decode cycles.
// Reset:
//   Synchronous, active high: returns the sequencer to idle and selects
//   double precision. Captured value registers are not cleared.
// Output:
//   The receiver cannot stall; each character is valid for exactly one
//   cycle and is taken at the edge that ends it.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module float_hex_text_formatter
   import fhtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value_bits,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_character,
   output logic        rsp_last_char,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_double_precision
);

   cmd_type    cmd;
   status_type status;

   // Mode register accepts a write whenever the channel offers one.
   assign csr_ready = 1'b1;

   // Sequencer: accept, decode wait, character stepping.
   fhtf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .status        (status),
      .cmd           (cmd),
      .rsp_strobe    (rsp_strobe),
      .rsp_last_char (rsp_last_char)
   );

   // Field decode, decimal exponent and character mux.
   fhtf_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_valid && csr_ready),
      .csr_double_precision (csr_double_precision),
      .req_value_bits       (req_value_bits),
      .cmd                  (cmd),
      .status               (status),
      .rsp_character        (rsp_character)
   );

   // Checks on the sequencing.
   `AST_IMPLIES(a_last_has_strobe, clock, reset, rsp_last_char, rsp_strobe, "last without strobe")
   `AST_IMPLIES(a_strobe_when_busy, clock, reset, rsp_strobe, busy, "strobe while idle")
   `AST_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not go busy")
   `AST_NEXT(a_last_frees, clock, reset, rsp_strobe && rsp_last_char, !busy, "busy after last char")

endmodule

// ===== bench/testbench.sv =====
// ------------------------------------------------------------------------
// testbench
// Self-checking bench for float_hex_text_formatter. Values go in on the
// start/busy command port. Each transaction is predicted into a queue of
// expected characters and checked in order against the rsp_ stream. The
// format register is rewritten between phases so that both double and
// single precision are covered.
// ------------------------------------------------------------------------
module testbench
   import fhtf_pkg::*;
;

   // Expected character of the formatted text, with its end-of-text flag.
   typedef struct {
      ascii_type ch;
      logic      last;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_value_bits = '0;
   logic        rsp_strobe;
   logic [6:0]  rsp_character;
   logic        rsp_last_char;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_double_precision = 1'b0;

   // Values waiting to be sent, and the characters the block still owes.
   logic [63:0]   value_q[$];
   text_char_type text_q[$];

   // Format as the block should currently see it (reset selects double).
   bit fmt_double = 1'b1;

   int errors = 0;
   int burst_left = 0;
   int gap_left = 0;

   float_hex_text_formatter u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_value_bits       (req_value_bits),
      .rsp_strobe           (rsp_strobe),
      .rsp_character        (rsp_character),
      .rsp_last_char        (rsp_last_char),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_double_precision (csr_double_precision)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Build the hex text of one value and append it to the expected stream.
   // A NaN appends nothing.
   function automatic void predict_text(input logic [63:0] bits, input bit dbl);
      ascii_type   txt[$];
      logic        neg;
      int          bexp;
      int          ones;
      logic [63:0] frac;
      int          nibs;
      int          bias;
      int          last;
      int          e;
      int unsigned mag;
      int          digs[8];
      int          nd;
      logic [3:0]  nib;
      text_char_type tc;
      if (dbl) begin
         neg  = bits[63];
         bexp = int'(bits[62:52]);
         ones = 'h7FF;
         frac = {12'd0, bits[51:0]};
         nibs = 13;
         bias = 1023;
      end else begin
         // single: ignore the upper word, widen the fraction to six nibbles
         neg  = bits[31];
         bexp = int'(bits[30:23]);
         ones = 'hFF;
         frac = {40'd0, bits[22:0], 1'b0};
         nibs = 6;
         bias = 127;
      end
      if (bexp == ones && frac != 0) begin
         return;
      end
      if (neg) begin
         txt.push_back(CH_MINUS);
      end
      if (bexp == ones) begin
         txt.push_back(CH_I);
         txt.push_back(CH_N);
         txt.push_back(CH_F);
      end else begin
         txt.push_back(CH_ZERO);
         txt.push_back(CH_X);
         txt.push_back((bexp == 0) ? CH_ZERO : CH_ONE);
         if (frac != 0) begin
            // drop trailing zero nibbles, keep at least one
            last = nibs - 1;
            while (last > 0 && ((frac >> (4 * (nibs - 1 - last))) & 64'hF) == 0) begin
               last--;
            end
            txt.push_back(CH_DOT);
            for (int i = 0; i <= last; i++) begin
               nib = 4'((frac >> (4 * (nibs - 1 - i))) & 64'hF);
               txt.push_back((nib < 4'd10) ? ascii_type'(CH_ZERO + nib)
                                           : ascii_type'(CH_A + nib - 4'd10));
            end
         end
         if (bexp == 0 && frac == 0) begin
            e = 0;
         end else if (bexp == 0) begin
            e = 1 - bias;
         end else begin
            e = bexp - bias;
         end
         txt.push_back(CH_P);
         txt.push_back((e < 0) ? CH_MINUS : CH_PLUS);
         mag = (e < 0) ? -e : e;
         nd = 0;
         do begin
            digs[nd] = mag % 10;
            nd++;
            mag = mag / 10;
         end while (mag != 0);
         for (int k = nd - 1; k >= 0; k--) begin
            txt.push_back(ascii_type'(CH_ZERO + digs[k]));
         end
      end
      foreach (txt[i]) begin
         tc.ch   = txt[i];
         tc.last = (i == txt.size() - 1);
         text_q.push_back(tc);
      end
   endfunction

   // Draw a value with weighted exponent and fraction classes so that zeros,
   // subnormals, infinities, NaNs, short fractions and small exponents of
   // both signs come up often. The remaining bits stay fully random.
   function automatic logic [63:0] rand_value(input bit dbl);
      logic [63:0] v;
      int unsigned ecls;
      int unsigned fcls;
      v = {$urandom, $urandom};
      ecls = $urandom_range(0, 9);
      fcls = $urandom_range(0, 5);
      if (dbl) begin
         case (ecls)
            0: v[62:52] = '0;
            1: v[62:52] = '1;
            2, 3: v[62:52] = 11'(1003 + $urandom_range(0, 40));
            default: ;
         endcase
         case (fcls)
            0: v[51:0] = '0;
            1, 2: v[51:0] = v[51:0] << (4 * $urandom_range(1, 12));
            default: ;
         endcase
      end else begin
         case (ecls)
            0: v[30:23] = '0;
            1: v[30:23] = '1;
            2, 3: v[30:23] = 8'(107 + $urandom_range(0, 40));
            default: ;
         endcase
         case (fcls)
            0: v[22:0] = '0;
            1, 2: v[22:0] = v[22:0] << (4 * $urandom_range(1, 5));
            default: ;
         endcase
      end
      return v;
   endfunction

   // Driver: hold start until the block takes the transaction, then either
   // advance to the next value or drop start for a random gap between bursts.
   always @(posedge clock) begin
      logic        nxt_start;
      logic [63:0] nxt_bits;
      if (reset) begin
         start          <= 1'b0;
         req_value_bits <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         nxt_start = start;
         nxt_bits  = req_value_bits;
         if (start && !busy) begin
            predict_text(req_value_bits, fmt_double);
            nxt_start = 1'b0;
         end
         if (!nxt_start) begin
            if (gap_left > 0) begin
               gap_left--;
               nxt_bits = {$urandom, $urandom};
            end else if (value_q.size() > 0) begin
               nxt_bits  = value_q.pop_front();
               nxt_start = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; a quarter of bursts follow back to back
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end
         end
         start          <= nxt_start;
         req_value_bits <= nxt_bits;
      end
   end

   // Monitor: every strobe must match the oldest expected character.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_strobe) begin
         if (text_q.size() == 0) begin
            $error("character: expected none, actual %h", rsp_character);
            errors++;
         end else begin
            want = text_q.pop_front();
            if (rsp_character !== want.ch) begin
               $error("character: expected %h, actual %h", want.ch, rsp_character);
               errors++;
            end
            if (rsp_last_char !== want.last) begin
               $error("last_char: expected %0b, actual %0b", want.last, rsp_last_char);
               errors++;
            end
         end
      end
   end

   // Wait until every value is sent and every character has come back, then
   // let a NaN still in decode finish before the block is touched again.
   task automatic wait_drained();
      do @(negedge clock);
      while (value_q.size() != 0 || start || text_q.size() != 0);
      repeat (32) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   // Write the format register and mirror it in the predictor.
   task automatic write_format(input bit dbl);
      @(posedge clock);
      csr_valid            <= 1'b1;
      csr_double_precision <= dbl;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid            <= 1'b0;
      csr_double_precision <= 1'b0;
      fmt_double = dbl;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, double precision from the reset value of the register.
      value_q.push_back(64'h0000_0000_0000_0000);   // +0
      value_q.push_back(64'h8000_0000_0000_0000);   // -0
      value_q.push_back(64'h3FF0_0000_0000_0000);   // 1.0
      value_q.push_back(64'hBFF8_0000_0000_0000);   // -1.5, one nibble
      value_q.push_back(64'h3FF0_0000_0000_0001);   // all thirteen nibbles
      value_q.push_back(64'h7FEF_FFFF_FFFF_FFFF);   // largest normal, p+1023
      value_q.push_back(64'h0010_0000_0000_0000);   // smallest normal, p-1022
      value_q.push_back(64'h0000_0000_0000_0001);   // smallest subnormal
      value_q.push_back(64'h800F_FFFF_FFFF_FFFF);   // largest negative subnormal
      value_q.push_back(64'h7FF0_0000_0000_0000);   // +inf
      value_q.push_back(64'hFFF0_0000_0000_0000);   // -inf
      value_q.push_back(64'h7FF8_0000_0000_0000);   // quiet NaN
      value_q.push_back(64'hFFF0_0000_0000_0001);   // negative NaN, low payload
      value_q.push_back(64'h4009_21FB_5444_2D18);   // pi
      wait_drained();

      // Directed, single precision with junk in the ignored upper word.
      write_format(1'b0);
      value_q.push_back(64'hFFFF_FFFF_0000_0000);   // +0
      value_q.push_back(64'h0000_0000_8000_0000);   // -0
      value_q.push_back(64'hA5A5_A5A5_3F80_0000);   // 1.0
      value_q.push_back(64'h0000_0000_7F7F_FFFF);   // largest normal
      value_q.push_back(64'h0000_0000_0080_0000);   // smallest normal, p-126
      value_q.push_back(64'h0000_0000_0000_0001);   // smallest subnormal
      value_q.push_back(64'h0000_0000_807F_FFFF);   // largest negative subnormal
      value_q.push_back(64'h0000_0000_7F80_0000);   // +inf
      value_q.push_back(64'hFFFF_FFFF_FF80_0000);   // -inf
      value_q.push_back(64'h0000_0000_7FC0_0000);   // quiet NaN
      value_q.push_back(64'h0000_0000_FF80_0001);   // negative NaN
      wait_drained();

      // Random phases, alternating the format each time.
      for (int ph = 0; ph < 5; ph++) begin
         write_format((ph % 2) == 0);
         for (int i = 0; i < 31; i++) begin
            value_q.push_back(rand_value(fmt_double));
         end
         wait_drained();
      end

      repeat (40) @(negedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: the run needs well under a tenth of this.
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
